FILE: design/stlmd_pkg.sv
`default_nettype none
package stlmd_pkg;

  localparam int MAX_WIDTH_DEF  = 128;
  localparam int MAX_HEIGHT_DEF = 128;
  localparam int SLOT_W         = 2;
  localparam int DIM_W          = 8;
  localparam int SAMPLE_W       = 8;
  localparam int POS_W          = 7;
  localparam int OUT_DATA_W     = 16;

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CTR_RD,
    ST_CTR_LD,
    ST_SCAN,
    ST_LAST,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic       accept;
    logic       ctr_rd;
    logic       ctr_load;
    logic       nb_rd;
    logic [1:0] back;
    logic [1:0] dr;
    logic [1:0] dc;
    logic       out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic valid_now;
    logic out_busy;
  } ctrl_status_t;

endpackage
`default_nettype wire

FILE: design/spatiotemporal_local_max_detector.sv
`default_nettype none
// 3x3x3 local maximum detector over a raster stream of 8-bit responses. Each
// input transfer writes its pixel into a four-slot frame store and yields one
// result for the same position two frames back: valid_res is 1 once three
// frames are complete, and is_extremum is 1 when that pixel is >= every
// in-image neighbour in its 3x3 window of the three previous frames. While
// results are valid an item runs from the accepting cycle through the centre
// read and its load, 27 neighbour reads on the frame store's single read port,
// the last compare on its registered read data and the result load; before
// that an item runs from the accepting cycle to the result load. The next input
// is taken while a finished result still waits at the output; a second finished
// result waits until the first has been taken. The user writes frame_width and
// frame_height (register 0 and 1) only while idle; the block does not enforce it.
module spatiotemporal_local_max_detector
  import stlmd_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_idx_i,
  input  wire logic [DIM_W-1:0]      cfg_wdata_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [SAMPLE_W-1:0]   s_axis_tdata,  // response
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata   // valid_res, is_extremum, out_row, out_col
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  stlmd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  stlmd_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  a_invalid_no_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> !m_axis_tdata[1])
    else $error("extremum marked before frames are valid");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrites one not yet taken");

endmodule
`default_nettype wire

FILE: design/stlmd_ctrl.sv
`default_nettype none
module stlmd_ctrl
  import stlmd_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire ctrl_status_t status_i,
  output ctrl_cmd_t         cmd_o
);

  ctrl_state_e state_q, state_d;
  logic [1:0]  back_q, back_d, dr_q, dr_d, dc_q, dc_d;
  logic        accept;
  logic        scan_end;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign scan_end = (back_q == 2'd3) && (dr_q == 2'd2) && (dc_q == 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      back_q  <= 2'd1;
      dr_q    <= 2'd0;
      dc_q    <= 2'd0;
    end else begin
      state_q <= state_d;
      back_q  <= back_d;
      dr_q    <= dr_d;
      dc_q    <= dc_d;
    end
  end

  // next state and scan counters
  always_comb begin
    state_d = state_q;
    back_d  = back_q;
    dr_d    = dr_q;
    dc_d    = dc_q;
    case (state_q)
      ST_IDLE: begin
        back_d = 2'd1;
        dr_d   = 2'd0;
        dc_d   = 2'd0;
        if (accept) begin
          state_d = status_i.valid_now ? ST_CTR_RD : ST_DONE;
        end
      end
      ST_CTR_RD: state_d = ST_CTR_LD;
      ST_CTR_LD: state_d = ST_SCAN;
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_LAST;
        end else if (dc_q == 2'd2) begin
          dc_d = 2'd0;
          if (dr_q == 2'd2) begin
            dr_d   = 2'd0;
            back_d = back_q + 2'd1;
          end else begin
            dr_d = dr_q + 2'd1;
          end
        end else begin
          dc_d = dc_q + 2'd1;
        end
      end
      ST_LAST: state_d = ST_DONE;
      ST_DONE: begin
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o      = (state_q == ST_IDLE);
    cmd_o.accept    = accept;
    cmd_o.ctr_rd    = (state_q == ST_CTR_RD);
    cmd_o.ctr_load  = (state_q == ST_CTR_LD);
    cmd_o.nb_rd     = (state_q == ST_SCAN);
    cmd_o.back      = back_q;
    cmd_o.dr        = dr_q;
    cmd_o.dc        = dc_q;
    cmd_o.out_load  = (state_q == ST_DONE) && !status_i.out_busy;
  end

endmodule
`default_nettype wire

FILE: design/stlmd_dp.sv
`default_nettype none
module stlmd_dp
  import stlmd_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_idx_i,
  input  wire logic [DIM_W-1:0]      cfg_wdata_i,
  input  wire logic [SAMPLE_W-1:0]   sample_i,
  input  wire ctrl_cmd_t             cmd_i,
  output ctrl_status_t               status_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0]      out_data_o
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = (1 << SLOT_W) << (RW + CW);
  localparam int AW    = SLOT_W + RW + CW;

  logic [DIM_W-1:0]    width_q, height_q;
  logic [CW:0]         eff_w;
  logic [RW:0]         eff_h;
  logic [CW-1:0]       col_q;
  logic [RW-1:0]       row_q;
  logic [1:0]          seen_q;
  logic [SLOT_W-1:0]   wslot_q;
  logic [CW-1:0]       it_col_q;
  logic [RW-1:0]       it_row_q;
  logic [SLOT_W-1:0]   it_slot_q;
  logic                it_valid_q;
  logic [SAMPLE_W-1:0] center_q;
  logic                ext_q;
  logic                cmp_q;
  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;
  logic [AW-1:0]       raddr, waddr;
  logic [RW:0]         nr;
  logic [CW:0]         nc;
  logic                inb;
  logic [SLOT_W-1:0]   rslot;
  logic [CW:0]         col_nx;
  logic [RW:0]         row_nx;
  logic                out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [RW+POS_W-1:0] row_ext;
  logic [CW+POS_W-1:0] col_ext;

  always_comb begin
    if (width_q == '0) begin
      eff_w = (CW+1)'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      eff_w = (CW+1)'(MAX_WIDTH);
    end else begin
      eff_w = (CW+1)'(width_q);
    end
    if (height_q == '0) begin
      eff_h = (RW+1)'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      eff_h = (RW+1)'(MAX_HEIGHT);
    end else begin
      eff_h = (RW+1)'(height_q);
    end
  end

  // neighbour address and border test
  always_comb begin
    nr  = {1'b0, it_row_q} + (RW+1)'(cmd_i.dr) - (RW+1)'(1);
    nc  = {1'b0, it_col_q} + (CW+1)'(cmd_i.dc) - (CW+1)'(1);
    inb = !((it_row_q == '0) && (cmd_i.dr == 2'd0)) &&
          !((it_col_q == '0) && (cmd_i.dc == 2'd0)) &&
          (nr < eff_h) && (nc < eff_w);
    if (cmd_i.ctr_rd) begin
      rslot = it_slot_q - SLOT_W'(2);
      raddr = {rslot, it_row_q, it_col_q};
    end else begin
      rslot = it_slot_q - SLOT_W'(cmd_i.back);
      raddr = {rslot, nr[RW-1:0], nc[CW-1:0]};
    end
    waddr  = {wslot_q, row_q, col_q};
    col_nx = {1'b0, col_q} + (CW+1)'(1);
    row_nx = {1'b0, row_q} + (RW+1)'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mem[waddr] <= sample_i;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(128);
      height_q <= DIM_W'(128);
      col_q    <= '0;
      row_q    <= '0;
      seen_q   <= '0;
      wslot_q  <= '0;
      cmp_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FRAME_WIDTH:  width_q  <= cfg_wdata_i;
          CFG_FRAME_HEIGHT: height_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        if (col_nx >= eff_w) begin
          col_q <= '0;
          if (row_nx >= eff_h) begin
            row_q   <= '0;
            wslot_q <= wslot_q + SLOT_W'(1);
            if (seen_q != 2'd3) begin
              seen_q <= seen_q + 2'd1;
            end
          end else begin
            row_q <= row_nx[RW-1:0];
          end
        end else begin
          col_q <= col_nx[CW-1:0];
        end
      end
      cmp_q <= cmd_i.nb_rd && inb;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign row_ext = (RW+POS_W)'(it_row_q);
  assign col_ext = (CW+POS_W)'(it_col_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      it_row_q   <= row_q;
      it_col_q   <= col_q;
      it_slot_q  <= wslot_q;
      it_valid_q <= (seen_q == 2'd3);
      ext_q      <= 1'b0;
    end else if (cmd_i.ctr_load) begin
      center_q <= rdata_q;
      ext_q    <= 1'b1;
    end else if (cmp_q && (rdata_q > center_q)) begin
      ext_q <= 1'b0;
    end
    if (cmd_i.out_load) begin
      out_data_q <= {col_ext[POS_W-1:0], row_ext[POS_W-1:0], ext_q, it_valid_q};
    end
  end

  assign status_o.valid_now = (seen_q == 2'd3);
  assign status_o.out_busy  = out_valid_q && !out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_data_q;

endmodule
`default_nettype wire

FILE: test/stlmd_peak_checker.sv
module stlmd_peak_checker
  import stlmd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [DIM_W-1:0]      cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [SAMPLE_W-1:0]   s_axis_tdata,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // lowest bit first: valid_res, is_extremum, out_row, out_col
  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             ext;
    logic             vld;
  } peak_report_t;

  logic [SAMPLE_W-1:0] frames [4][MAX_HEIGHT_DEF][MAX_WIDTH_DEF];
  logic [DIM_W-1:0]    width_reg  = 8'd128;
  logic [DIM_W-1:0]    height_reg = 8'd128;
  int                  row_pos    = 0;
  int                  col_pos    = 0;
  int                  frames_done = 0;
  int                  wr_slot    = 0;
  peak_report_t        expected_reports [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    for (int s = 0; s < 4; s++)
      for (int r = 0; r < MAX_HEIGHT_DEF; r++)
        for (int c = 0; c < MAX_WIDTH_DEF; c++)
          frames[s][r][c] = '0;
  end

  function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : int'(v);
  endfunction

  task automatic predict_report(input logic [SAMPLE_W-1:0] sample);
    int           w;
    int           h;
    int           slot;
    int           nr;
    int           nc;
    logic [7:0]   centre;
    peak_report_t rep;
    w = clamp_dim(width_reg, MAX_WIDTH_DEF);
    h = clamp_dim(height_reg, MAX_HEIGHT_DEF);
    rep.vld = (frames_done >= 3);
    rep.ext = 1'b0;
    rep.row = row_pos[POS_W-1:0];
    rep.col = col_pos[POS_W-1:0];
    if (rep.vld) begin
      centre  = frames[(wr_slot + 2) % 4][row_pos][col_pos];
      rep.ext = 1'b1;
      for (int b = 1; b <= 3; b++) begin
        slot = (wr_slot + 4 - b) % 4;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            nr = row_pos + dr;
            nc = col_pos + dc;
            if (nr >= 0 && nc >= 0 && nr < h && nc < w)
              if (centre < frames[slot][nr][nc]) rep.ext = 1'b0;
          end
        end
      end
    end
    frames[wr_slot][row_pos][col_pos] = sample;
    expected_reports = {expected_reports, rep};
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) begin
        row_pos = 0;
        wr_slot = (wr_slot + 1) % 4;
        if (frames_done < 3) frames_done++;
      end
    end
  endtask

  task automatic compare_report(input peak_report_t got);
    peak_report_t want;
    if (expected_reports.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("unexpected result transfer: %h", got);
      return;
    end
    want = expected_reports.pop_front();
    if (got.vld !== want.vld || got.ext !== want.ext ||
        got.row !== want.row || got.col !== want.col) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("mismatch: expected vld %0d ext %0d row %0d col %0d, got vld %0d ext %0d row %0d col %0d",
                 want.vld, want.ext, want.row, want.col, got.vld, got.ext, got.row, got.col);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) compare_report(peak_report_t'(m_axis_tdata));
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_FRAME_WIDTH) width_reg = cfg_wdata_i;
        else height_reg = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) predict_report(s_axis_tdata);
      pending_o = expected_reports.size();
    end
  end

endmodule

FILE: test/tb_spatiotemporal_local_max_detector.sv
module tb_spatiotemporal_local_max_detector;
  import stlmd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic                  cfg_idx_i;
  logic [DIM_W-1:0]      cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [SAMPLE_W-1:0]   s_axis_tdata;   // response
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // valid_res, is_extremum, out_row, out_col
  int                    fail_count;
  int                    pending;
  bit                    long_hold = 1'b0;
  int                    random_items;

  spatiotemporal_local_max_detector dut (.*);

  stlmd_peak_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // result side back-pressure
  initial begin
    int k;
    m_axis_tready = 1'b0;
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end else begin
        k = $urandom_range(0, 99);
        if (k < 50) begin
          m_axis_tready <= 1'b1;
          repeat ($urandom_range(1, 30)) @(posedge clk_i);
        end else if (k < 95) begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk_i);
        end else begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(10, 60)) @(posedge clk_i);
        end
      end
    end
  end

  task automatic send_response(input logic [SAMPLE_W-1:0] v);
    int k;
    int gap;
    k   = $urandom_range(0, 99);
    gap = (k < 70) ? 0 : (k < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // drains the block before touching a size register
  task automatic write_size(input logic idx, input logic [DIM_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_burst(input int n);
    repeat (n) send_response(8'($urandom));
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_response(input int mode, input int base);
    int k;
    k = $urandom_range(0, 99);
    case (mode)
      0: return 8'($urandom);
      1: return (k < 33) ? 8'd0 : (k < 66) ? 8'd255 : 8'($urandom_range(100, 103));
      default: return (k < 90) ? 8'(base) : 8'($urandom);
    endcase
  endfunction

  initial begin
    int n;
    int mode;
    int base;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_FRAME_WIDTH;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first frame: oversized sizes act as 128, a full row, a 9 wide block, then one column
    write_size(CFG_FRAME_WIDTH, 8'd255);
    write_size(CFG_FRAME_HEIGHT, 8'd200);
    send_burst(128);
    write_size(CFG_FRAME_WIDTH, 8'd9);
    send_burst(72);
    write_size(CFG_FRAME_WIDTH, 8'd1);
    send_burst(119);
    // two 9x9 frames, then an 8x8 frame: every slot holds rows and columns 0..7
    write_size(CFG_FRAME_WIDTH, 8'd9);
    write_size(CFG_FRAME_HEIGHT, 8'd9);
    send_burst(162);
    write_size(CFG_FRAME_WIDTH, 8'd8);
    write_size(CFG_FRAME_HEIGHT, 8'd8);
    send_burst(64);

    write_size(CFG_FRAME_WIDTH, 8'd1);
    write_size(CFG_FRAME_HEIGHT, 8'd1);
    send_response(8'd0);
    send_response(8'd255);
    send_response(8'd255);
    send_response(8'd128);
    write_size(CFG_FRAME_WIDTH, 8'd255);
    write_size(CFG_FRAME_HEIGHT, 8'd4);
    repeat (6) send_response(8'($urandom));
    // shrink the width behind the current column
    write_size(CFG_FRAME_WIDTH, 8'd2);
    repeat (3) send_response(8'd255);
    write_size(CFG_FRAME_WIDTH, 8'd0);
    write_size(CFG_FRAME_HEIGHT, 8'd0);
    send_response(8'd0);
    send_response(8'd1);
    write_size(CFG_FRAME_WIDTH, 8'd3);
    write_size(CFG_FRAME_HEIGHT, 8'd3);
    repeat (9) send_response(8'd77);

    // sizes stay within the stored 8x8 area
    random_items = 0;
    while (random_items < 900) begin
      w = 8'($urandom_range(0, 8));
      h = 8'($urandom_range(0, 8));
      write_size(CFG_FRAME_WIDTH, w);
      write_size(CFG_FRAME_HEIGHT, h);
      if (random_items == 0) long_hold = 1'b1;
      n    = $urandom_range(30, 150);
      mode = $urandom_range(0, 2);
      base = $urandom_range(0, 255);
      repeat (n) send_response(pick_response(mode, base));
      random_items += n;
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
